[src/slcr_pkg.sv]
package slcr_pkg;

  localparam int MAX_RESULTS = 32;

  localparam logic ITEM_ECHO = 1'b0;
  localparam logic ITEM_LINE = 1'b1;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_FORWARD = 3'd1;
  localparam logic [2:0] CMD_BACK    = 3'd2;
  localparam logic [2:0] CMD_LEFT    = 3'd3;
  localparam logic [2:0] CMD_RIGHT   = 3'd4;
  localparam logic [2:0] CMD_STOP    = 3'd5;
  localparam logic [2:0] CMD_SPEED   = 3'd6;

  localparam logic [7:0] CH_Z  = 8'h7a;
  localparam logic [7:0] CH_S  = 8'h73;
  localparam logic [7:0] CH_Q  = 8'h71;
  localparam logic [7:0] CH_D  = 8'h64;
  localparam logic [7:0] CH_A  = 8'h61;
  localparam logic [7:0] CH_V  = 8'h76;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;

  // One classified item handed from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] cmd;
    logic       term;
  } job_t;

  function automatic logic [2:0] demo_code(input logic [7:0] b);
    logic [2:0] c;
    case (b)
      CH_Z:    c = CMD_FORWARD;
      CH_S:    c = CMD_BACK;
      CH_Q:    c = CMD_LEFT;
      CH_D:    c = CMD_RIGHT;
      CH_A:    c = CMD_STOP;
      CH_V:    c = CMD_SPEED;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

[src/slcr_ram.sv]
module slcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/slcr_fifo.sv]
module slcr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  slcr_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output slcr_pkg::job_t head_job,
  output logic          empty
);
  import slcr_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full)
    else $error("slcr_fifo: push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("slcr_fifo: pop from empty queue");

endmodule

[src/slcr_front.sv]
module slcr_front #(
  parameter int LINE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_demo_enable,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  output logic                          push,
  output slcr_pkg::job_t                push_job,
  input  logic                          q_full,
  input  logic                          line_done,
  output logic                          mem_we,
  output logic [$clog2(LINE_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                    mem_wdata
);
  import slcr_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  logic          demo_enable_r;
  logic [AW-1:0] fill_count_r, fill_count_nxt;
  logic          line_busy_r, line_busy_nxt;
  logic          accept;
  logic          is_term;
  logic [2:0]    cmd;
  logic [AW:0]   fill_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && !line_busy_r;
  assign accept    = in_valid && in_ready;
  assign is_term   = (in_rx_byte == CH_LF) || (in_rx_byte == CH_CR);
  assign cmd       = demo_enable_r ? demo_code(in_rx_byte) : CMD_NONE;
  assign fill_inc  = {1'b0, fill_count_r} + {{AW{1'b0}}, 1'b1};

  // Store a terminator as zero so the drain stops on it
  assign mem_we    = accept;
  assign mem_waddr = fill_count_r;
  assign mem_wdata = is_term ? 8'h00 : in_rx_byte;

  assign push          = accept;
  assign push_job.data = in_rx_byte;
  assign push_job.cmd  = cmd;
  assign push_job.term = is_term;

  always_comb begin
    fill_count_nxt = fill_count_r;
    line_busy_nxt  = line_busy_r;
    if (line_done) begin
      line_busy_nxt = 1'b0;
    end
    if (accept) begin
      if (is_term || cmd == CMD_SPEED || fill_inc == (AW + 1)'(LINE_DEPTH)) begin
        fill_count_nxt = '0;
      end else begin
        fill_count_nxt = fill_inc[AW-1:0];
      end
      // Hold off new bytes until the line has been read out of the store
      if (is_term) begin
        line_busy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      demo_enable_r <= 1'b0;
      fill_count_r  <= '0;
      line_busy_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        demo_enable_r <= cfg_demo_enable;
      end
      fill_count_r <= fill_count_nxt;
      line_busy_r  <= line_busy_nxt;
    end
  end

  a_term_restarts_line: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_term) |=> (fill_count_r == '0 && line_busy_r))
    else $error("slcr_front: terminator did not restart the line");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, fill_count_r} < (AW + 1)'(LINE_DEPTH))
    else $error("slcr_front: fill count out of range");

endmodule

[src/slcr_back.sv]
module slcr_back #(
  parameter int LINE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  slcr_pkg::job_t                head_job,
  output logic                          pop,
  output logic                          line_done,
  output logic [$clog2(LINE_DEPTH)-1:0] mem_raddr,
  input  logic [7:0]                    mem_rdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_item_kind,
  output logic [7:0]                    out_data_byte,
  output logic [2:0]                    out_command_code,
  output logic                          out_line_ready,
  output logic                          out_last
);
  import slcr_pkg::*;

  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int CAP = (MAX_RESULTS - 1 < LINE_DEPTH) ? MAX_RESULTS - 1 : LINE_DEPTH;
  localparam logic [AW:0] CAP_IDX = (AW + 1)'(CAP);

  typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_EMIT} state_t;
  typedef enum logic [1:0] {NX_NONE, NX_FINAL, NX_READ} next_t;

  state_t        state_r, state_nxt;
  next_t         after_r, after_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          term_job_r, term_job_nxt;
  logic          pend_kind_r, pend_kind_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;
  logic [2:0]    pend_cmd_r, pend_cmd_nxt;
  logic          pend_lr_r, pend_lr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic [2:0]    out_cmd_r, out_cmd_nxt;
  logic          out_lr_r, out_lr_nxt;
  logic          out_last_r, out_last_nxt;
  logic [AW:0]   idx_inc;

  assign idx_inc = {1'b0, idx_r} + {{AW{1'b0}}, 1'b1};

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    idx_nxt       = idx_r;
    term_job_nxt  = term_job_r;
    pend_kind_nxt = pend_kind_r;
    pend_byte_nxt = pend_byte_r;
    pend_cmd_nxt  = pend_cmd_r;
    pend_lr_nxt   = pend_lr_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_cmd_nxt   = out_cmd_r;
    out_lr_nxt    = out_lr_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    line_done     = 1'b0;
    mem_raddr     = '0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop           = 1'b1;
          term_job_nxt  = head_job.term;
          pend_kind_nxt = ITEM_ECHO;
          pend_byte_nxt = head_job.data;
          pend_cmd_nxt  = head_job.cmd;
          pend_lr_nxt   = head_job.term;
          if (head_job.term) begin
            // Fetch the first line byte to learn whether the echo is last
            idx_nxt   = '0;
            state_nxt = ST_WAIT;
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = ITEM_ECHO;
            out_byte_nxt  = head_job.data;
            out_cmd_nxt   = head_job.cmd;
            out_lr_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            after_nxt     = NX_NONE;
            state_nxt     = ST_EMIT;
          end
        end
      end
      ST_WAIT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = pend_kind_r;
        out_byte_nxt  = pend_byte_r;
        out_cmd_nxt   = pend_cmd_r;
        out_lr_nxt    = pend_lr_r;
        state_nxt     = ST_EMIT;
        if (mem_rdata == 8'h00) begin
          out_last_nxt = 1'b1;
          after_nxt    = NX_NONE;
        end else begin
          out_last_nxt  = 1'b0;
          pend_kind_nxt = ITEM_LINE;
          pend_byte_nxt = mem_rdata;
          pend_cmd_nxt  = CMD_NONE;
          pend_lr_nxt   = 1'b0;
          after_nxt     = (idx_inc == CAP_IDX) ? NX_FINAL : NX_READ;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          case (after_r)
            NX_FINAL: begin
              out_kind_nxt = pend_kind_r;
              out_byte_nxt = pend_byte_r;
              out_cmd_nxt  = pend_cmd_r;
              out_lr_nxt   = pend_lr_r;
              out_last_nxt = 1'b1;
              after_nxt    = NX_NONE;
            end
            NX_READ: begin
              out_valid_nxt = 1'b0;
              idx_nxt       = idx_inc[AW-1:0];
              mem_raddr     = idx_inc[AW-1:0];
              state_nxt     = ST_WAIT;
            end
            default: begin
              out_valid_nxt = 1'b0;
              line_done     = term_job_r;
              state_nxt     = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      after_r     <= NX_NONE;
      term_job_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      term_job_r  <= term_job_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_cmd_r  <= pend_cmd_nxt;
    pend_lr_r   <= pend_lr_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_cmd_r   <= out_cmd_nxt;
    out_lr_r    <= out_lr_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_item_kind    = out_kind_r;
  assign out_data_byte    = out_byte_r;
  assign out_command_code = out_cmd_r;
  assign out_line_ready   = out_lr_r;
  assign out_last         = out_last_r;

  a_valid_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_EMIT))
    else $error("slcr_back: result shown outside emit state");

  a_line_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == ITEM_LINE) |-> (out_cmd_r == CMD_NONE && !out_lr_r))
    else $error("slcr_back: line character carries status");

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    line_done |-> (out_valid_r && out_ready && out_last_r))
    else $error("slcr_back: line finished without a last item");

endmodule

[src/serial_line_command_receiver.sv]
// Serial line command receiver.
// Input channel: one received byte per item on in_rx_byte (in_valid/in_ready).
// Result channel: out_valid/out_ready with item kind, data byte, command code,
// line-ready flag and last mark. Every byte yields an echo item first; a CR or
// LF byte is followed by the stored line characters, cut at the first zero
// byte, and the last mark closes the items of that byte.
// Config channel: cfg_valid/cfg_ready writes demo_enable, which turns on the
// z s q d a v motion commands (v also discards the line so far).
// A front stage stores bytes in the line RAM and queues them in a two-entry
// queue; a back stage forms the results. A plain byte passes through the queue
// and the output register, and the back stage takes the next byte only once
// it has finished the items of the last one. Each line character goes from the
// registered RAM read through a pending register into the output register. New
// bytes are held off from a terminator until its drain completes.
// Reset clears the fill count, demo mode and all handshake state; RAM contents
// are not cleared. A stalled out_ready holds the current result; the front
// keeps accepting until the queue fills.
module serial_line_command_receiver #(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_demo_enable,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_item_kind,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_command_code,
  output logic       out_line_ready,
  output logic       out_last
);
  import slcr_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  logic          push, pop, q_full, q_empty, line_done;
  job_t          push_job, head_job;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  slcr_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_demo_enable (cfg_demo_enable),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .push            (push),
    .push_job        (push_job),
    .q_full          (q_full),
    .line_done       (line_done),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata)
  );

  slcr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  slcr_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  slcr_back #(.LINE_DEPTH(LINE_DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head_job         (head_job),
    .pop              (pop),
    .line_done        (line_done),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item_kind    (out_item_kind),
    .out_data_byte    (out_data_byte),
    .out_command_code (out_command_code),
    .out_line_ready   (out_line_ready),
    .out_last         (out_last)
  );

endmodule
